/* design/utcl_pkg.sv */
// shared types, constants and helper functions for the local date-time text unit
`timescale 1ns / 1ps

package utcl_pkg;

  localparam int unsigned TextLen  = 22;
  localparam int unsigned TextIdxW = $clog2(TextLen);

  typedef logic [7:0] char_t;

  localparam char_t CharZero  = 8'h30;
  localparam char_t CharDash  = 8'h2D;
  localparam char_t CharSpace = 8'h20;
  localparam char_t CharColon = 8'h3A;
  localparam char_t CharA     = 8'h41;
  localparam char_t CharP     = 8'h50;
  localparam char_t CharM     = 8'h4D;

  // days per month code, codes outside 1..12 count as 31 days
  localparam logic [4:0] MonthDays [16] = '{
    5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
  };

  // one formatted text line waiting for the serializer
  typedef struct packed {
    logic                      not_set;
    char_t [TextLen-1:0]       text;
  } utcl_job_t;

  function automatic logic [4:0] month_len(input logic [3:0] mo, input logic leap);
    logic [4:0] len;
    len = MonthDays[mo];
    if (mo == 4'd2 && leap) begin
      len = 5'd29;
    end
    return len;
  endfunction

  // two ascii digits of a value below 100, tens in the upper byte
  function automatic logic [15:0] two_digits(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = 15'(v) * 15'd205;
    tens = prod[14:11];
    ones = v - 7'(tens) * 7'd10;
    return {CharZero + {4'b0000, tens}, CharZero + {4'b0000, ones[3:0]}};
  endfunction

endpackage

/* design/utcl_in_if.sv */
// input channel: utc date and time, offset and clock-set flag
`timescale 1ns / 1ps

interface utcl_in_if;
  logic               valid;
  logic               ready;
  logic               clock_set;
  logic [13:0]        year;
  logic [3:0]         month;
  logic [4:0]         day;
  logic [4:0]         hour;
  logic [5:0]         minute;
  logic [5:0]         second;
  logic signed [11:0] offset_minutes;

  modport source (
    output valid, clock_set, year, month, day, hour, minute, second, offset_minutes,
    input  ready
  );

  modport sink (
    input  valid, clock_set, year, month, day, hour, minute, second, offset_minutes,
    output ready
  );
endinterface

/* design/utcl_out_if.sv */
// output channel: one text character per word
`timescale 1ns / 1ps

interface utcl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last_char;
  logic       not_set;

  modport source (
    output valid, text_char, last_char, not_set,
    input  ready
  );

  modport sink (
    input  valid, text_char, last_char, not_set,
    output ready
  );
endinterface

/* design/utcl_front.sv */
// front pipeline: offset add, day carry, calendar stepping and text formatting
`timescale 1ns / 1ps

module utcl_front import utcl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  utcl_in_if.sink   in_i,
  output logic      push_o,
  output utcl_job_t job_o,
  input  logic      full_i
);

  localparam int unsigned NumStages = 6;
  localparam int          MinPerDay = 1440;

  typedef struct packed {
    logic               cs;
    logic [4:0]         dd;
    logic [3:0]         mo;
    logic [5:0]         sec;
    logic signed [13:0] total;
    logic [13:0]        yr;
    logic [26:0]        yprod;
    logic [10:0]        tod;
    logic               fwd;
    logic [1:0]         steps;
    logic [7:0]         yhi;
    logic [6:0]         ylo;
    logic               leap;
    logic [4:0]         hh;
    logic [5:0]         mm;
    logic               pm;
    logic [3:0]         h12;
  } stage_t;

  stage_t                 st_q [NumStages];
  stage_t                 st_d [NumStages];
  logic [NumStages-1:0]   vld_q;
  utcl_job_t              job_q, job_d;
  logic                   job_vld_q;
  logic                   adv;

  // one day forward or back, year kept as two base-100 halves
  function automatic stage_t day_step(input stage_t s);
    stage_t r;
    r = s;
    if (s.steps != 2'd0) begin
      r.steps = s.steps - 2'd1;
      if (s.fwd) begin
        if (s.dd >= month_len(s.mo, s.leap)) begin
          r.dd = 5'd1;
          if (s.mo >= 4'd12) begin
            r.mo = 4'd1;
            if (s.ylo == 7'd99) begin
              r.ylo = 7'd0;
              r.yhi = s.yhi + 8'd1;
            end else begin
              r.ylo = s.ylo + 7'd1;
            end
          end else begin
            r.mo = s.mo + 4'd1;
          end
        end else begin
          r.dd = s.dd + 5'd1;
        end
      end else begin
        if (s.dd <= 5'd1) begin
          if (s.mo <= 4'd1) begin
            r.mo = 4'd12;
            // year zero stepping back prints as 9999
            if (s.ylo == 7'd0) begin
              r.ylo = 7'd99;
              r.yhi = (s.yhi == 8'd0) ? 8'd99 : s.yhi - 8'd1;
            end else begin
              r.ylo = s.ylo - 7'd1;
            end
          end else begin
            r.mo = s.mo - 4'd1;
          end
          r.dd = month_len(r.mo, s.leap);
        end else begin
          r.dd = s.dd - 5'd1;
        end
      end
    end
    return r;
  endfunction

  assign adv        = !job_vld_q || !full_i;
  assign in_i.ready = adv;
  assign push_o     = job_vld_q && !full_i;
  assign job_o      = job_q;

  always_comb begin
    logic [11:0] hm;
    logic [13:0] lo_full;
    logic [21:0] tprod;
    logic [10:0] mrem;
    logic [4:0]  h5;

    // minutes of day plus offset, and year times reciprocal of 100
    hm = 12'(in_i.hour) * 12'd60 + 12'(in_i.minute);
    st_d[0]       = '0;
    st_d[0].cs    = in_i.clock_set;
    st_d[0].dd    = in_i.day;
    st_d[0].mo    = in_i.month;
    st_d[0].sec   = in_i.second;
    st_d[0].yr    = in_i.year;
    st_d[0].total = $signed({2'b00, hm}) + {{2{in_i.offset_minutes[11]}}, in_i.offset_minutes};
    st_d[0].yprod = 27'(in_i.year) * 27'd5243;

    // fold total into one day, at most two days either way
    st_d[1] = st_q[0];
    if (st_q[0].total < -14'(MinPerDay)) begin
      st_d[1].tod   = 11'(st_q[0].total + 14'(2 * MinPerDay));
      st_d[1].fwd   = 1'b0;
      st_d[1].steps = 2'd2;
    end else if (st_q[0].total < 14'sd0) begin
      st_d[1].tod   = 11'(st_q[0].total + 14'(MinPerDay));
      st_d[1].fwd   = 1'b0;
      st_d[1].steps = 2'd1;
    end else if (st_q[0].total >= 14'(2 * MinPerDay)) begin
      st_d[1].tod   = 11'(st_q[0].total - 14'(2 * MinPerDay));
      st_d[1].fwd   = 1'b1;
      st_d[1].steps = 2'd2;
    end else if (st_q[0].total >= 14'(MinPerDay)) begin
      st_d[1].tod   = 11'(st_q[0].total - 14'(MinPerDay));
      st_d[1].fwd   = 1'b1;
      st_d[1].steps = 2'd1;
    end else begin
      st_d[1].tod   = 11'(st_q[0].total);
      st_d[1].fwd   = 1'b0;
      st_d[1].steps = 2'd0;
    end
    st_d[1].yhi = st_q[0].yprod[26:19];
    lo_full     = st_q[0].yr - 14'(st_q[0].yprod[26:19]) * 14'd100;
    st_d[1].ylo = lo_full[6:0];
    // century years are leap only when the century count is a multiple of 4
    st_d[1].leap = (lo_full[6:0] == 7'd0) ? (st_q[0].yprod[20:19] == 2'b00)
                                          : (st_q[0].yr[1:0] == 2'b00);

    st_d[2] = day_step(st_q[1]);
    st_d[3] = day_step(st_q[2]);

    // hour = tod / 60 by reciprocal
    st_d[4]    = st_q[3];
    tprod      = 22'(st_q[3].tod) * 22'd1093;
    st_d[4].hh = tprod[20:16];

    st_d[5]    = st_q[4];
    mrem       = st_q[4].tod - 11'(st_q[4].hh) * 11'd60;
    st_d[5].mm = mrem[5:0];
    st_d[5].pm = (st_q[4].hh >= 5'd12);
    if (st_q[4].hh > 5'd12) begin
      h5 = st_q[4].hh - 5'd12;
    end else if (st_q[4].hh == 5'd0) begin
      h5 = 5'd12;
    end else begin
      h5 = st_q[4].hh;
    end
    st_d[5].h12 = h5[3:0];
    if (st_q[4].yhi >= 8'd100) begin
      st_d[5].yhi = st_q[4].yhi - 8'd100;
    end

    job_d.not_set  = !st_q[5].cs;
    {job_d.text[0], job_d.text[1]}   = two_digits(st_q[5].yhi[6:0]);
    {job_d.text[2], job_d.text[3]}   = two_digits(st_q[5].ylo);
    job_d.text[4]                    = CharDash;
    {job_d.text[5], job_d.text[6]}   = two_digits({3'b000, st_q[5].mo});
    job_d.text[7]                    = CharDash;
    {job_d.text[8], job_d.text[9]}   = two_digits({2'b00, st_q[5].dd});
    job_d.text[10]                   = CharSpace;
    {job_d.text[11], job_d.text[12]} = two_digits({3'b000, st_q[5].h12});
    job_d.text[13]                   = CharColon;
    {job_d.text[14], job_d.text[15]} = two_digits({1'b0, st_q[5].mm});
    job_d.text[16]                   = CharColon;
    {job_d.text[17], job_d.text[18]} = two_digits({1'b0, st_q[5].sec});
    job_d.text[19]                   = CharSpace;
    job_d.text[20]                   = st_q[5].pm ? CharP : CharA;
    job_d.text[21]                   = CharM;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      job_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[NumStages-2:0], in_i.valid};
      job_vld_q <= vld_q[NumStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NumStages; i++) begin
        st_q[i] <= st_d[i];
      end
      job_q <= job_d;
    end
  end

endmodule

/* design/utcl_fifo.sv */
// short queue of formatted lines between the front pipeline and the serializer
`timescale 1ns / 1ps

module utcl_fifo import utcl_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  utcl_job_t job_i,
  output logic      full_o,
  output logic      valid_o,
  output utcl_job_t job_o,
  input  logic      pop_i
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  utcl_job_t       mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

/* design/utcl_back.sv */
// serializer: sends one queued line as a run of characters, one per word
`timescale 1ns / 1ps

module utcl_back import utcl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  input  utcl_job_t  job_i,
  output logic       pop_o,
  utcl_out_if.source out_o
);

  logic [TextIdxW-1:0] idx_q;
  logic                valid_q;
  char_t               char_q;
  logic                last_q;
  logic                ns_q;
  logic                load;
  logic                at_end;

  assign load   = job_valid_i && (!valid_q || out_o.ready);
  // a not-set line is a single word
  assign at_end = job_i.not_set || (idx_q == TextIdxW'(TextLen - 1));
  assign pop_o  = load && at_end;

  assign out_o.valid     = valid_q;
  assign out_o.text_char = char_q;
  assign out_o.last_char = last_q;
  assign out_o.not_set   = ns_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load) begin
      valid_q <= 1'b1;
      idx_q   <= at_end ? '0 : idx_q + 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= job_i.not_set ? '0 : job_i.text[idx_q];
      last_q <= at_end;
      ns_q   <= job_i.not_set;
    end
  end

endmodule

/* design/utc_to_local_datetime_text_unit.sv */
// top level: utc date-time plus offset to 12-hour local text
//
// in_i takes one utc date and time with a signed offset in minutes and a
// clock-set flag per word. out_o returns 22 ascii words per item,
// "YYYY-MM-DD HH:MM:SS AM", last_char marking the final one; an item with
// clock_set low gives a single word with text_char 0 and not_set high.
// The first word of an item passes through the front pipeline's stage and
// job registers, the line queue, then the output register. The serializer
// sends one character per cycle while out_o.ready is high; a not-set item
// gives one word. The front pipeline takes a word every cycle until its
// job register holds a line and the QueueDepth-entry line queue is full,
// so up to 7 + QueueDepth items can be taken ahead of the serializer.
// When out_o.ready is low the output word holds, the serializer waits, and
// the queue then the front pipeline fill before in_i.ready drops.
// Reset (rst_ni low, asynchronous) empties the pipeline, queue and output
// register; no item is lost or repeated across a stall.
`timescale 1ns / 1ps

module utc_to_local_datetime_text_unit import utcl_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  utcl_in_if.sink    in_i,
  utcl_out_if.source out_o
);

  utcl_job_t push_job, head_job;
  logic      push, full, head_valid, pop;

  utcl_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .push_o (push),
    .job_o  (push_job),
    .full_i (full)
  );

  utcl_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .valid_o (head_valid),
    .job_o   (head_job),
    .pop_i   (pop)
  );

  utcl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (head_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule
